// ===== design/pbd_pkg.sv =====
package pbd_pkg;

    // Field widths
    localparam int BYTE_W  = 8;
    localparam int WIDTH_W = 16;
    localparam int PW_W    = WIDTH_W + 1;
    localparam int RGB_W   = 3 * BYTE_W;

    // Default palette depth
    localparam int PAL_ENTRIES_DEF = 256;

    // PackBits header constants
    localparam logic [BYTE_W-1:0] HDR_NOP  = 8'd128;
    localparam logic [BYTE_W:0]   RUN_BASE = 9'd257;

    // Input item kinds (carried in s_tuser)
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_BODY = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] CFG_COMPRESSED = 2'd0;
    localparam logic [1:0] CFG_WIDTH      = 2'd1;
    localparam logic [1:0] CFG_TRANSP_ON  = 2'd2;
    localparam logic [1:0] CFG_TRANSP_IDX = 2'd3;

    localparam logic [WIDTH_W-1:0] WIDTH_RESET = 16'd64;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'b001,
        PH_LITERAL = 3'b010,
        PH_RUNVAL  = 3'b100
    } phase_t;

    typedef struct packed {
        logic                compressed;
        logic [WIDTH_W-1:0]  width;
        logic                transp_on;
        logic [BYTE_W-1:0]   transp_idx;
    } cfg_t;

    // One decoded pixel transaction waiting for its palette lookup
    typedef struct packed {
        logic [BYTE_W-1:0] count;
        logic              over;
        logic              transp;
    } pix_t;

endpackage

// ===== design/pbd_decoder.sv =====
module pbd_decoder
    import pbd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              accept,
    input  logic              opcode,
    input  logic [BYTE_W-1:0] body_byte,
    input  logic              a_ready,
    output logic              a_valid_reg,
    output pix_t              a_pix_reg
);

    phase_t              phase_reg, phase_next;
    logic [BYTE_W-1:0]   lit_reg, lit_next;
    logic [BYTE_W-1:0]   run_reg, run_next;
    logic [WIDTH_W-1:0]  col_reg, col_next;

    logic [PW_W-1:0]     pw;
    logic                pw_zero;
    logic [WIDTH_W-1:0]  col;
    logic                col_vis;

    logic                s_emit;
    logic [PW_W-1:0]     s_col1;
    logic [WIDTH_W-1:0]  s_next;

    logic [PW_W-1:0]     left;
    logic [PW_W-1:0]     run17;
    logic [PW_W-1:0]     take;
    logic                r_over;
    logic [PW_W-1:0]     room;
    logic [PW_W-1:0]     vis;
    logic                r_emit;
    logic [PW_W-1:0]     r_col;
    logic [WIDTH_W-1:0]  r_next;

    logic                emit;
    pix_t                pix;

    // Column bookkeeping shared by single bytes and runs
    always_comb
    begin
        pw      = {1'b0, cfg.width} + {{WIDTH_W{1'b0}}, cfg.width[0]};
        pw_zero = (pw == '0);
        col     = ({1'b0, col_reg} >= pw) ? '0 : col_reg;
        col_vis = (col < cfg.width);

        // One byte, one column
        s_emit = !pw_zero && col_vis;
        s_col1 = {1'b0, col} + {{WIDTH_W{1'b0}}, 1'b1};
        s_next = (pw_zero || s_col1 >= pw) ? '0 : s_col1[WIDTH_W-1:0];

        // Run clipped to the rest of the padded row
        left   = pw - {1'b0, col};
        run17  = {{(PW_W-BYTE_W){1'b0}}, run_reg};
        take   = (run17 < left) ? run17 : left;
        r_over = (run17 > left);
        room   = {1'b0, cfg.width} - {1'b0, col};
        vis    = !col_vis ? '0 : ((room < take) ? room : take);
        r_emit = !pw_zero && (vis != '0);
        r_col  = {1'b0, col} + take;
        r_next = (pw_zero || r_col >= pw) ? '0 : r_col[WIDTH_W-1:0];
    end

    // Advance the decode state for one body byte
    always_comb
    begin
        phase_next = phase_reg;
        lit_next   = lit_reg;
        run_next   = run_reg;
        col_next   = col_reg;
        emit       = 1'b0;
        pix.count  = 8'd1;
        pix.over   = 1'b0;
        pix.transp = cfg.transp_on && (body_byte == cfg.transp_idx);

        if (accept && opcode == OP_BODY)
        begin
            if (!cfg.compressed)
            begin
                emit     = s_emit;
                col_next = s_next;
            end
            else
            begin
                unique case (phase_reg)
                    PH_LITERAL:
                    begin
                        lit_next = (lit_reg != '0) ? lit_reg - 8'd1 : '0;
                        if (lit_reg <= 8'd1)
                        begin
                            phase_next = PH_HEADER;
                        end
                        emit     = s_emit;
                        col_next = s_next;
                    end
                    PH_RUNVAL:
                    begin
                        phase_next = PH_HEADER;
                        emit       = r_emit;
                        col_next   = r_next;
                        pix.count  = vis[BYTE_W-1:0];
                        pix.over   = r_over;
                    end
                    PH_HEADER:
                    begin
                        if (body_byte < HDR_NOP)
                        begin
                            lit_next   = body_byte + 8'd1;
                            phase_next = PH_LITERAL;
                        end
                        else if (body_byte > HDR_NOP)
                        begin
                            run_next   = BYTE_W'(RUN_BASE - {1'b0, body_byte});
                            phase_next = PH_RUNVAL;
                        end
                        else
                        begin
                            phase_next = PH_HEADER;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_HEADER;
                    end
                endcase
            end
        end
    end

    // Hold decode state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            lit_reg   <= '0;
            run_reg   <= '0;
            col_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            lit_reg   <= lit_next;
            run_reg   <= run_next;
            col_reg   <= col_next;
        end
    end

    // Lookup stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (a_ready)
        begin
            a_valid_reg <= emit;
        end
    end

    // Lookup stage payload
    always_ff @(posedge clk)
    begin
        if (a_ready)
        begin
            a_pix_reg <= pix;
        end
    end

endmodule

// ===== design/pbd_palette.sv =====
module pbd_palette
    import pbd_pkg::*;
#(
    parameter int PALETTE_ENTRIES = PAL_ENTRIES_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              we,
    input  logic [BYTE_W-1:0] wr_index,
    input  logic [RGB_W-1:0]  wr_rgb,
    input  logic              rd_en,
    input  logic [BYTE_W-1:0] rd_index,
    output logic              rd_hit_reg,
    output logic [RGB_W-1:0]  rd_rgb_reg
);

    localparam int ADDR_W = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

    logic [RGB_W-1:0]           mem [PALETTE_ENTRIES];
    logic [PALETTE_ENTRIES-1:0] vld_reg;

    logic wr_in_range;
    logic rd_in_range;

    assign wr_in_range = ({1'b0, wr_index} < (BYTE_W+1)'(PALETTE_ENTRIES));
    assign rd_in_range = ({1'b0, rd_index} < (BYTE_W+1)'(PALETTE_ENTRIES));

    // Write entry, read registered
    always_ff @(posedge clk)
    begin
        if (we && wr_in_range)
        begin
            mem[wr_index[ADDR_W-1:0]] <= wr_rgb;
        end
        if (rd_en)
        begin
            rd_rgb_reg <= mem[rd_index[ADDR_W-1:0]];
        end
    end

    // Entries read as black until loaded
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_hit_reg <= 1'b0;
        end
        else
        begin
            if (we && wr_in_range)
            begin
                vld_reg[wr_index[ADDR_W-1:0]] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_hit_reg <= rd_in_range && vld_reg[rd_index[ADDR_W-1:0]];
            end
        end
    end

endmodule

// ===== design/pbd_output.sv =====
module pbd_output
    import pbd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              a_valid,
    input  pix_t              a_pix,
    input  logic              rd_hit,
    input  logic [RGB_W-1:0]  rd_rgb,
    output logic              out_ready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [31:0]       m_tdata,
    output logic [1:0]        m_tuser
);

    logic              valid_reg;
    logic [RGB_W-1:0]  rgb_reg;
    logic [BYTE_W-1:0] count_reg;
    logic              opaque_reg;
    logic              over_reg;

    assign out_ready = !valid_reg || m_tready;

    // Result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            valid_reg <= a_valid;
        end
    end

    // Map color, blank transparent and unloaded entries
    always_ff @(posedge clk)
    begin
        if (out_ready)
        begin
            rgb_reg    <= (rd_hit && !a_pix.transp) ? rd_rgb : '0;
            count_reg  <= a_pix.count;
            opaque_reg <= !a_pix.transp;
            over_reg   <= a_pix.over;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {count_reg, rgb_reg};
    assign m_tuser  = {over_reg, opaque_reg};

endmodule

// ===== design/packbits_palette_pixel_decoder.sv =====
// Pipeline: an accepted body byte is registered in the lookup stage together with its
// palette read, then in the output stage that drives m_tvalid. Throughput: one input
// transaction per cycle unless the output stalls; palette loads and header bytes give no result.
// Reset: rst_n clears the decoder to expect a header at column zero, marks all
// palette entries unloaded (black) and restores the configuration defaults.
module packbits_palette_pixel_decoder
    import pbd_pkg::*;
#(
    parameter int PALETTE_ENTRIES = PAL_ENTRIES_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wr_en,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [39:0]  s_tdata,  // body_byte, entry_index, entry_red, entry_green, entry_blue
    input  logic         s_tuser,  // opcode
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [31:0]  m_tdata,  // pixel_red, pixel_green, pixel_blue, repeat_count
    output logic [1:0]   m_tuser   // opaque, run_overran
);

    cfg_t  cfg_reg;
    logic  accept;
    logic  out_ready;
    logic  a_valid;
    pix_t  a_pix;
    logic  rd_hit;
    logic [RGB_W-1:0] rd_rgb;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.compressed <= 1'b0;
            cfg_reg.width      <= WIDTH_RESET;
            cfg_reg.transp_on  <= 1'b0;
            cfg_reg.transp_idx <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_COMPRESSED: cfg_reg.compressed <= cfg_data[0];
                CFG_WIDTH:      cfg_reg.width      <= cfg_data;
                CFG_TRANSP_ON:  cfg_reg.transp_on  <= cfg_data[0];
                CFG_TRANSP_IDX: cfg_reg.transp_idx <= cfg_data[BYTE_W-1:0];
                default:        cfg_reg.compressed <= cfg_reg.compressed;
            endcase
        end
    end

    // Take a transaction whenever the lookup stage can move on
    assign s_tready = !a_valid || out_ready;
    assign accept   = s_tvalid && s_tready;

    pbd_decoder u_decoder (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .accept      (accept),
        .opcode      (s_tuser),
        .body_byte   (s_tdata[7:0]),
        .a_ready     (s_tready),
        .a_valid_reg (a_valid),
        .a_pix_reg   (a_pix)
    );

    pbd_palette #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_palette (
        .clk        (clk),
        .rst_n      (rst_n),
        .we         (accept && s_tuser == OP_LOAD),
        .wr_index   (s_tdata[15:8]),
        .wr_rgb     (s_tdata[39:16]),
        .rd_en      (s_tready),
        .rd_index   (s_tdata[7:0]),
        .rd_hit_reg (rd_hit),
        .rd_rgb_reg (rd_rgb)
    );

    pbd_output u_output (
        .clk       (clk),
        .rst_n     (rst_n),
        .a_valid   (a_valid),
        .a_pix     (a_pix),
        .rd_hit    (rd_hit),
        .rd_rgb    (rd_rgb),
        .out_ready (out_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

// ===== design/pbd_checker.sv =====
module pbd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // Hold a stalled result transaction
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // Count stays within one run
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[31:24] != 8'd0 && m_tdata[31:24] <= 8'd128)
        else $error("repeat count out of range");

    // Transparent pixels are black
    a_transp: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata[23:0] == 24'd0)
        else $error("transparent pixel carries color");

    // Overrun is flagged only on a transaction with a nonzero count
    a_over: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> m_tdata[31:24] != 8'd0)
        else $error("overrun flagged on empty run");

endmodule

bind packbits_palette_pixel_decoder pbd_checker u_pbd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top
    import pbd_pkg::*;
();

    // One expected or observed pixel transaction
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       opaque;
        logic [7:0] count;
        logic       over;
    } pixel_t;

    // One line of the directed plan: a register write or an input transaction
    typedef struct {
        bit          is_cfg;
        logic [1:0]  reg_idx;
        logic [15:0] reg_val;
        logic        op;
        logic [39:0] data;
        bit          typed;
        pixel_t      want;
    } plan_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // body_byte, entry_index, entry_red, entry_green, entry_blue
    logic        s_tuser;   // opcode
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // pixel_red, pixel_green, pixel_blue, repeat_count
    logic [1:0]  m_tuser;   // opaque, run_overran

    packbits_palette_pixel_decoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // Clock, 4 ns period
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Decoder state as the testbench sees it
    logic [23:0] palette [256];
    phase_t      dec_phase;
    int          lit_left;
    int          run_len;
    int          col;
    bit          cfg_compressed;
    int          cfg_width;
    bit          cfg_transp_on;
    logic [7:0]  cfg_transp_idx;

    pixel_t      pix_q [$];
    plan_row_t   plan [$];

    int          src_idle;
    int          snk_idle;
    int          errors;
    int          n_in;
    int          n_pix;
    int          n_clip;
    int          n_transp;

    function automatic int padded_width();
        return cfg_width + (cfg_width & 1);
    endfunction

    // Look up the color of one index, honoring the transparent index
    function automatic pixel_t color_of(logic [7:0] idx, int cnt, bit ov);
        pixel_t p;
        p = '0;
        p.opaque = 1'b1;
        if (cfg_transp_on && idx == cfg_transp_idx)
            p.opaque = 1'b0;
        else
            {p.red, p.green, p.blue} = palette[idx];
        p.count = cnt[7:0];
        p.over  = ov;
        return p;
    endfunction

    // Place one byte on one column; the pad column gives nothing
    function automatic bit place_single(logic [7:0] idx, output pixel_t p);
        int pw;
        bit hit;
        pw  = padded_width();
        hit = 1'b0;
        p   = '0;
        if (col >= pw)
            col = 0;
        if (pw == 0)
            return 1'b0;
        if (col < cfg_width)
        begin
            p   = color_of(idx, 1, 1'b0);
            hit = 1'b1;
        end
        col++;
        if (col >= pw)
            col = 0;
        return hit;
    endfunction

    // Place a run, clipped at the end of the padded row
    function automatic bit place_run(logic [7:0] idx, output pixel_t p);
        int pw;
        int left;
        int take;
        int vis;
        bit ov;
        bit hit;
        pw  = padded_width();
        hit = 1'b0;
        p   = '0;
        if (col >= pw)
            col = 0;
        if (pw == 0)
            return 1'b0;
        left = pw - col;
        take = (run_len < left) ? run_len : left;
        ov   = (run_len > left);
        vis  = 0;
        if (col < cfg_width)
        begin
            vis = cfg_width - col;
            if (vis > take)
                vis = take;
        end
        if (vis > 0)
        begin
            p   = color_of(idx, vis, ov);
            hit = 1'b1;
        end
        col += take;
        if (col >= pw)
            col = 0;
        return hit;
    endfunction

    // Advance the decoder by one accepted input transaction
    function automatic bit decode_item(logic op, logic [39:0] d, output pixel_t p);
        logic [7:0] b;
        b = d[7:0];
        p = '0;
        if (op == OP_LOAD)
        begin
            palette[d[15:8]] = {d[23:16], d[31:24], d[39:32]};
            return 1'b0;
        end
        if (!cfg_compressed)
            return place_single(b, p);
        case (dec_phase)
            PH_LITERAL:
            begin
                if (lit_left > 0)
                    lit_left--;
                if (lit_left == 0)
                    dec_phase = PH_HEADER;
                return place_single(b, p);
            end
            PH_RUNVAL:
            begin
                dec_phase = PH_HEADER;
                return place_run(b, p);
            end
            default:
            begin
                dec_phase = PH_HEADER;
                if (b < HDR_NOP)
                begin
                    lit_left  = int'(b) + 1;
                    dec_phase = PH_LITERAL;
                end
                else if (b > HDR_NOP)
                begin
                    run_len   = int'(RUN_BASE) - int'(b);
                    dec_phase = PH_RUNVAL;
                end
                return 1'b0;
            end
        endcase
    endfunction

    function automatic pixel_t px(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                  logic opq, logic [7:0] cnt, logic ov);
        pixel_t p;
        p.red    = r;
        p.green  = g;
        p.blue   = b;
        p.opaque = opq;
        p.count  = cnt;
        p.over   = ov;
        return p;
    endfunction

    function automatic plan_row_t r_cfg(logic [1:0] idx, logic [15:0] val);
        plan_row_t r;
        r = '{default: '0};
        r.is_cfg  = 1'b1;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    function automatic plan_row_t r_body(logic [7:0] b);
        plan_row_t r;
        r = '{default: '0};
        r.op   = OP_BODY;
        r.data = {32'h0, b};
        return r;
    endfunction

    function automatic plan_row_t r_pix(logic [7:0] b, pixel_t want);
        plan_row_t r;
        r = r_body(b);
        r.typed = 1'b1;
        r.want  = want;
        return r;
    endfunction

    function automatic plan_row_t r_load(logic [7:0] i, logic [7:0] red,
                                         logic [7:0] green, logic [7:0] blue);
        plan_row_t r;
        r = '{default: '0};
        r.op   = OP_LOAD;
        r.data = {blue, green, red, i, 8'h00};
        return r;
    endfunction

    // Bias pixel indexes toward the transparent index and the low indexes 0 to 15
    function automatic logic [7:0] pick_index();
        int sel;
        sel = $urandom_range(3);
        if (sel == 0)
            return cfg_transp_idx;
        if (sel == 1)
            return 8'($urandom_range(15));
        return 8'($urandom_range(255));
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    // Hold the sender until every pixel has come and the pipeline is empty
    task automatic quiesce();
        s_tvalid <= 1'b0;
        while (pix_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        quiesce();
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_COMPRESSED: cfg_compressed = val[0];
            CFG_WIDTH:      cfg_width      = int'(val);
            CFG_TRANSP_ON:  cfg_transp_on  = val[0];
            CFG_TRANSP_IDX: cfg_transp_idx = val[7:0];
            default: ;
        endcase
    endtask

    // Drive one input transaction and record what it should produce
    task automatic send_item(logic op, logic [39:0] d, bit typed, pixel_t want);
        pixel_t p;
        while ($urandom_range(99) < src_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= d;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        n_in++;
        if (decode_item(op, d, p))
            pix_q.push_back(typed ? want : p);
    endtask

    task automatic send_body(logic [7:0] b);
        logic [31:0] junk;
        junk = $urandom();
        send_item(OP_BODY, {junk, b}, 1'b0, '0);
    endtask

    task automatic pick_setup();
        int sel;
        logic [15:0] w;
        sel = $urandom_range(19);
        if (sel == 0)
            w = 16'hFFFF;
        else if (sel == 1)
            w = 16'd0;
        else if (sel == 2)
            w = 16'($urandom_range(300, 13));
        else
            w = 16'($urandom_range(12, 1));
        write_reg(CFG_COMPRESSED, 16'($urandom_range(3) != 0));
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_TRANSP_ON, 16'($urandom_range(1)));
        write_reg(CFG_TRANSP_IDX, 16'($urandom_range(255)));
    endtask

    // Mostly well-formed PackBits packets with random content, some noise
    task automatic random_segment(int n_target);
        int sent;
        int kind;
        int len;
        logic [31:0] junk;
        sent = 0;
        while (sent < n_target)
        begin
            kind = $urandom_range(99);
            junk = $urandom();
            if (kind < 10)
            begin
                send_item(OP_LOAD, {junk[31:8], pick_index(), junk[7:0]}, 1'b0, '0);
                sent++;
            end
            else if (!cfg_compressed || kind < 18)
            begin
                send_body((kind & 1) ? pick_index() : 8'($urandom_range(255)));
                sent++;
            end
            else if (kind < 22)
            begin
                send_body(HDR_NOP);
                sent++;
            end
            else if (kind < 60)
            begin
                len = ($urandom_range(9) == 0) ? $urandom_range(127) : $urandom_range(7);
                send_body(8'(len));
                for (int k = 0; k <= len; k++)
                    send_body(pick_index());
                sent += len + 2;
            end
            else
            begin
                if ($urandom_range(1) == 0)
                    send_body(8'($urandom_range(255, 250)));
                else
                    send_body(8'($urandom_range(255, 129)));
                send_body(pick_index());
                sent += 2;
            end
        end
    endtask

    // Accept and check pixel transactions; stall the receiver at random
    initial
    begin
        pixel_t want;
        pixel_t got;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                got = px(m_tdata[7:0], m_tdata[15:8], m_tdata[23:16],
                         m_tuser[0], m_tdata[31:24], m_tuser[1]);
                if (pix_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected pixel transaction, expected none, actual %h",
                             $time, got);
                end
                else
                begin
                    want = pix_q.pop_front();
                    check_field("pixel_red", want.red, got.red);
                    check_field("pixel_green", want.green, got.green);
                    check_field("pixel_blue", want.blue, got.blue);
                    check_field("opaque", want.opaque, got.opaque);
                    check_field("repeat_count", want.count, got.count);
                    check_field("run_overran", want.over, got.over);
                    n_pix++;
                    n_clip   += want.over;
                    n_transp += !want.opaque;
                end
            end
            m_tready <= ($urandom_range(99) >= snk_idle);
        end
    end

    // Stop a hung run
    initial
    begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Reset, directed plan, then random traffic under three idle mixes
    initial
    begin
        rst_n     <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= CFG_COMPRESSED;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tuser   <= OP_LOAD;
        s_tdata   <= '0;
        foreach (palette[i])
            palette[i] = '0;
        dec_phase      = PH_HEADER;
        lit_left       = 0;
        run_len        = 0;
        col            = 0;
        cfg_compressed = 1'b0;
        cfg_width      = int'(WIDTH_RESET);
        cfg_transp_on  = 1'b0;
        cfg_transp_idx = '0;
        errors   = 0;
        n_in     = 0;
        n_pix    = 0;
        n_clip   = 0;
        n_transp = 0;
        src_idle = 19;
        snk_idle = 77;

        // Raw mode after reset: unloaded entries are black
        plan.push_back(r_pix(8'h00, px(8'h00, 8'h00, 8'h00, 1'b1, 8'd1, 1'b0)));
        plan.push_back(r_load(8'h00, 8'h12, 8'h34, 8'h56));
        plan.push_back(r_load(8'hFF, 8'hFF, 8'hFF, 8'hFF));
        plan.push_back(r_pix(8'hFF, px(8'hFF, 8'hFF, 8'hFF, 1'b1, 8'd1, 1'b0)));
        plan.push_back(r_pix(8'h00, px(8'h12, 8'h34, 8'h56, 1'b1, 8'd1, 1'b0)));
        // PackBits on an odd row that starts at its pad column
        plan.push_back(r_cfg(CFG_COMPRESSED, 16'd1));
        plan.push_back(r_cfg(CFG_WIDTH, 16'd3));
        plan.push_back(r_cfg(CFG_TRANSP_ON, 16'd1));
        plan.push_back(r_cfg(CFG_TRANSP_IDX, 16'hFF));
        plan.push_back(r_body(8'd2));
        plan.push_back(r_body(8'h00));
        plan.push_back(r_pix(8'hFF, px(8'h00, 8'h00, 8'h00, 1'b0, 8'd1, 1'b0)));
        plan.push_back(r_body(8'h00));
        plan.push_back(r_body(HDR_NOP));
        // Longest run, clipped at the row end
        plan.push_back(r_body(8'd129));
        plan.push_back(r_body(8'h00));
        // Zero width drops every byte
        plan.push_back(r_cfg(CFG_WIDTH, 16'd0));
        plan.push_back(r_body(8'd0));
        plan.push_back(r_body(8'hFF));
        // Widest row, raw then a full-length run
        plan.push_back(r_cfg(CFG_COMPRESSED, 16'd0));
        plan.push_back(r_cfg(CFG_WIDTH, 16'hFFFF));
        plan.push_back(r_cfg(CFG_TRANSP_ON, 16'd0));
        plan.push_back(r_pix(8'hFF, px(8'hFF, 8'hFF, 8'hFF, 1'b1, 8'd1, 1'b0)));
        plan.push_back(r_cfg(CFG_COMPRESSED, 16'd1));
        plan.push_back(r_body(8'd129));
        plan.push_back(r_pix(8'h00, px(8'h12, 8'h34, 8'h56, 1'b1, 8'd128, 1'b0)));
        // Shrink width mid-row; run on the pad column alone; run from column 0
        plan.push_back(r_cfg(CFG_WIDTH, 16'd1));
        plan.push_back(r_body(8'd0));
        plan.push_back(r_body(8'h00));
        plan.push_back(r_body(8'hFF));
        plan.push_back(r_body(8'h00));
        plan.push_back(r_body(8'hFF));
        plan.push_back(r_body(8'hFF));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
                write_reg(plan[i].reg_idx, plan[i].reg_val);
            else
                send_item(plan[i].op, plan[i].data, plan[i].typed, plan[i].want);
        end

        for (int ph = 0; ph < 3; ph++)
        begin
            src_idle = (ph == 0) ? 19 : ((ph == 1) ? 77 : 0);
            snk_idle = (ph == 0) ? 77 : ((ph == 1) ? 19 : 0);
            for (int seg = 0; seg < 3; seg++)
            begin
                pick_setup();
                random_segment(62);
            end
        end

        quiesce();
        repeat (8) @(posedge clk);
        $display("Sent %0d input transactions, checked %0d pixel transactions,", n_in, n_pix);
        $display("of which %0d were clipped runs and %0d transparent.", n_clip, n_transp);
        if (errors == 0 && pix_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
design/pbd_pkg.sv
design/pbd_decoder.sv
design/pbd_palette.sv
design/pbd_output.sv
design/packbits_palette_pixel_decoder.sv
design/pbd_checker.sv
verif/tb_top.sv
